### src/ps2md_pkg.sv
// shared types and constants for the ps2 mouse device responder
`timescale 1ns / 1ps
`default_nettype none
package ps2md_pkg;

	typedef enum logic [1:0] {
		CMD_HOST  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_SLOT  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	localparam logic KIND_HOST   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [7:0] BYTE_ACK      = 8'hFA;
	localparam logic [7:0] BYTE_BAT_OK   = 8'hAA;
	localparam logic [7:0] BYTE_DEV_ID   = 8'h10;
	localparam logic [7:0] HOST_RESET    = 8'hFF;
	localparam logic [7:0] HOST_RATE     = 8'hF3;
	localparam logic [7:0] HOST_RATE_VAL = 8'd40;
	localparam logic [7:0] HOST_READ     = 8'hEB;
	localparam logic [7:0] BTN_SYNC      = 8'h08;
	localparam logic [7:0] CLAMP_NEG     = 8'h80;
	localparam logic [7:0] CLAMP_POS     = 8'h7F;

	localparam logic [19:0] TIMEOUT_RESET = 20'd50000;
	localparam logic [19:0] TICK_MAX      = 20'hFFFFF;
	localparam logic [8:0]  AWAIT_LEN     = 9'h100;

	// result group produced by one request
	typedef struct packed {
		logic [2:0]      cnt;
		logic            kind;
		logic [3:0][7:0] bytes;
	} bundle_t;

endpackage
`default_nettype wire

### src/ps2_mouse_device_responder.sv
// top level of the ps2 mouse device responder
// usage:
//   requests enter on the s_ group; tuser is the command (host byte, tick,
//   send slot free, read status) and tdata carries the mouse sample, host byte
//   and status index. results leave on the m_ group one byte per cycle while m_tready is high; tuser
//   marks host bytes versus status read data, tlast the last byte of a request.
//   timeout_ticks is written on the cfg_ channel, which is always ready.
// a request is registered in the request register, decided there, and its
//   result bytes are registered in the output register before they are valid.
// requests are taken one per cycle while results drain; a request that makes
//   n result bytes (up to four) holds the output register until its last byte
//   is taken, so the next result-producing request waits for it.
// the status store is read when a request is taken and written when it is
//   decided, with same-edge forwarding between the two.
// reset: idle phase, timeout 50000, status store reads as zero until written.
// a stalled m_tready holds the current byte and backs up into s_tready.
`timescale 1ns / 1ps
`default_nettype none
module ps2_mouse_device_responder #(
	parameter int STATUS_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// host_byte[7:0], mouse_active[8], mouse_dx[24:9], mouse_dy[40:25],
	// mouse_buttons[43:41], status_index[47:44]
	input  wire  [47:0] s_tdata,
	// cmd[1:0]
	input  wire  [1:0]  s_tuser,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [19:0] cfg_data,
	output logic        m_tvalid,
	input  wire         m_tready,
	// out_byte[7:0]
	output logic [7:0]  m_tdata,
	// out_kind[0]
	output logic        m_tuser,
	output logic        m_tlast
);

	logic               out_free;
	logic               bun_load;
	ps2md_pkg::bundle_t bun;

	assign cfg_ready = 1'b1;

	ps2md_core #(
		.STATUS_DEPTH(STATUS_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.in_cmd   (s_tuser),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_value(cfg_data),
		.out_free (out_free),
		.bun_load (bun_load),
		.bun      (bun)
	);

	ps2md_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (bun_load),
		.bun_in  (bun),
		.free    (out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
`default_nettype wire

### src/ps2md_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ps2md_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                     wdata,
	input  wire                                  re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### src/ps2md_core.sv
// input register, protocol state and status store
`timescale 1ns / 1ps
`default_nettype none
module ps2md_core #(
	parameter int STATUS_DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  wire  [47:0]             in_data,
	input  wire  [1:0]              in_cmd,
	input  wire                     cfg_we,
	input  wire  [19:0]             cfg_value,
	input  wire                     out_free,
	output logic                    bun_load,
	output ps2md_pkg::bundle_t      bun
);

	localparam int AW = (STATUS_DEPTH > 1) ? $clog2(STATUS_DEPTH) : 1;
	localparam int PW = $clog2(STATUS_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SEND = 2'd1,
		PH_RECV = 2'd2
	} phase_t;

	// request register
	logic        vld_s1;
	logic [1:0]  cmd_s1;
	logic [7:0]  hb_s1;
	logic        act_s1;
	logic [15:0] dx_s1;
	logic [15:0] dy_s1;
	logic [2:0]  btn_s1;
	logic        rng_s1;
	logic        byp_s1;
	logic [7:0]  bypd_s1;
	logic        rvld_s1;

	phase_t      phase_q, phase_d;
	logic [PW-1:0] ptr_q, ptr_d;
	logic [8:0]  left_q, left_d;
	logic [19:0] ticks_q, ticks_d;
	logic [19:0] timeout_q;
	logic [STATUS_DEPTH-1:0] svld_q;

	logic          accept, commit;
	logic [8:0]    idx_w;
	logic [AW-1:0] raddr, waddr;
	logic          rng;
	logic          we;
	logic [7:0]    rdata;
	logic [8:0]    left_dec;
	logic [19:0]   ticks_inc;
	logic signed [16:0] ndy;
	logic [7:0]    dx_c, dy_c;
	ps2md_pkg::bundle_t res;

	assign idx_w  = 9'(in_data[47:44]);
	assign raddr  = idx_w[AW-1:0];
	assign rng    = idx_w < 9'(STATUS_DEPTH);
	assign waddr  = ptr_q[AW-1:0];

	assign commit   = vld_s1 && (out_free || res.cnt == 3'd0);
	assign in_ready = !vld_s1 || commit;
	assign accept   = in_valid && in_ready;
	assign bun_load = commit && res.cnt != 3'd0;
	assign bun      = res;

	ps2md_ram #(
		.WIDTH(8),
		.DEPTH(STATUS_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we && commit),
		.waddr(waddr),
		.wdata(hb_s1),
		.re   (accept),
		.raddr(raddr),
		.rdata(rdata)
	);

	// clamps
	assign ndy = -$signed({dy_s1[15], dy_s1});
	always_comb begin
		if ($signed(dx_s1) < -16'sd128) begin
			dx_c = ps2md_pkg::CLAMP_NEG;
		end else if ($signed(dx_s1) > 16'sd127) begin
			dx_c = ps2md_pkg::CLAMP_POS;
		end else begin
			dx_c = dx_s1[7:0];
		end
		if (ndy < -17'sd128) begin
			dy_c = ps2md_pkg::CLAMP_NEG;
		end else if (ndy > 17'sd127) begin
			dy_c = ps2md_pkg::CLAMP_POS;
		end else begin
			dy_c = ndy[7:0];
		end
	end

	assign left_dec  = left_q - 9'd1;
	assign ticks_inc = (ticks_q < ps2md_pkg::TICK_MAX) ? ticks_q + 20'd1 : ticks_q;

	always_comb begin
		phase_d   = phase_q;
		ptr_d     = ptr_q;
		left_d    = left_q;
		ticks_d   = ticks_q;
		we        = 1'b0;
		res.cnt   = 3'd0;
		res.kind  = ps2md_pkg::KIND_HOST;
		res.bytes = '0;
		unique case (ps2md_pkg::cmd_t'(cmd_s1))
			ps2md_pkg::CMD_HOST: begin
				if (phase_q == PH_IDLE) begin
					if (hb_s1 == ps2md_pkg::HOST_RESET) begin
						res.cnt      = 3'd3;
						res.bytes[0] = ps2md_pkg::BYTE_ACK;
						res.bytes[1] = ps2md_pkg::BYTE_BAT_OK;
						res.bytes[2] = ps2md_pkg::BYTE_DEV_ID;
					end else if (hb_s1 == ps2md_pkg::HOST_RATE ||
							hb_s1 == ps2md_pkg::HOST_RATE_VAL) begin
						res.cnt      = 3'd1;
						res.bytes[0] = ps2md_pkg::BYTE_ACK;
					end else if (hb_s1 == ps2md_pkg::HOST_READ) begin
						phase_d = PH_SEND;
					end
				end else if (phase_q == PH_RECV) begin
					ticks_d = '0;
					if (left_q[8]) begin
						left_d = 9'(hb_s1);
						if (hb_s1 == 8'd0) begin
							phase_d = PH_IDLE;
						end
					end else if (left_q != 9'd0) begin
						if (ptr_q < PW'(STATUS_DEPTH)) begin
							we    = 1'b1;
							ptr_d = ptr_q + PW'(1);
						end
						left_d = left_dec;
						if (left_dec == 9'd0) begin
							phase_d = PH_IDLE;
						end
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			ps2md_pkg::CMD_TICK: begin
				if (phase_q == PH_RECV) begin
					ticks_d = ticks_inc;
					if (ticks_inc > timeout_q) begin
						phase_d = PH_IDLE;
					end
				end
			end
			ps2md_pkg::CMD_SLOT: begin
				if (phase_q == PH_SEND) begin
					res.cnt      = 3'd4;
					res.bytes[0] = ps2md_pkg::BYTE_ACK;
					if (act_s1) begin
						res.bytes[1] = ps2md_pkg::BTN_SYNC | 8'(btn_s1);
						res.bytes[2] = dx_c;
						res.bytes[3] = dy_c;
					end
					phase_d = PH_RECV;
					ptr_d   = '0;
					left_d  = ps2md_pkg::AWAIT_LEN;
					ticks_d = '0;
				end
			end
			ps2md_pkg::CMD_READ: begin
				res.cnt  = 3'd1;
				res.kind = ps2md_pkg::KIND_STATUS;
				if (rng_s1) begin
					if (byp_s1) begin
						res.bytes[0] = bypd_s1;
					end else if (rvld_s1) begin
						res.bytes[0] = rdata;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			phase_q   <= PH_IDLE;
			ptr_q     <= '0;
			left_q    <= '0;
			ticks_q   <= '0;
			timeout_q <= ps2md_pkg::TIMEOUT_RESET;
			svld_q    <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_value;
			end
			if (commit) begin
				phase_q <= phase_d;
				ptr_q   <= ptr_d;
				left_q  <= left_d;
				ticks_q <= ticks_d;
				if (we) begin
					svld_q[waddr] <= 1'b1;
				end
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (commit) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// payload, with forwarding of a store write landing on the same edge
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= in_cmd;
			hb_s1   <= in_data[7:0];
			act_s1  <= in_data[8];
			dx_s1   <= in_data[24:9];
			dy_s1   <= in_data[40:25];
			btn_s1  <= in_data[43:41];
			rng_s1  <= rng;
			byp_s1  <= we && commit && waddr == raddr;
			bypd_s1 <= hb_s1;
			rvld_s1 <= rng && svld_q[raddr];
		end
	end

endmodule
`default_nettype wire

### src/ps2md_out.sv
// result register that hands out one byte of a group per cycle while m_tready is high
`timescale 1ns / 1ps
`default_nettype none
module ps2md_out (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  ps2md_pkg::bundle_t  bun_in,
	output logic                free,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tuser,
	output logic                m_tlast
);

	logic               have_q;
	logic [1:0]         pos_q;
	ps2md_pkg::bundle_t bun_q;
	logic [1:0]         last_pos;

	assign last_pos = 2'(bun_q.cnt - 3'd1);
	assign m_tvalid = have_q;
	assign m_tdata  = bun_q.bytes[pos_q];
	assign m_tuser  = bun_q.kind;
	assign m_tlast  = pos_q == last_pos;
	assign free     = !have_q || (m_tready && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			if (load) begin
				have_q <= 1'b1;
				pos_q  <= '0;
			end else if (have_q && m_tready) begin
				if (m_tlast) begin
					have_q <= 1'b0;
				end else begin
					pos_q <= pos_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bun_q <= bun_in;
		end
	end

endmodule
`default_nettype wire
